// ----- rtl/generational_handle_allocator_assert.svh -----
// assertion macros shared by the checker file
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_ASSERT_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define GHA_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define GHA_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/gha_pkg.sv -----
// ----------------------------------------------------------------------------
// gha_pkg
// Shared widths, command and status codes and parameter defaults of the
// generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

  localparam int SLOTS_DEF    = 1024;
  localparam int GEN_BITS_DEF = 16;

  localparam int CMD_W    = 2;
  localparam int IDX_FW   = 10;
  localparam int GEN_FW   = 16;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_CREATE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DESTROY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CHECK   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SLOT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DEAD    = 2'd2;

endpackage

// ----- rtl/generational_handle_allocator.sv -----
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Hands out slot handles (index, generation) from a LIFO free stack and
// checks or retires them against a per-slot generation and alive table.
// ----------------------------------------------------------------------------
//  channel | handshake          | fields
//  --------+--------------------+----------------------------------------------
//  in      | in_valid/in_stall  | cmd, handle_index, handle_generation
//  out     | out_valid/out_stall| status, out_index, out_generation, is_alive
//
//  destroy and check pass through the slot table read, then update and result;
//  create goes straight to update and result when no recycled index sits on the
//  stack (the index comes from a counter) or the stack is empty, and passes
//  through a stack read, then a slot read when it pops a recycled index
//  one word is worked on at a time; a new word is taken once the last is done
//  the tables need no clearing pass on reset: a fresh-slot count
//  marks which stack and slot entries were ever written
//  a stalled result holds the update stage, the input waits meanwhile
// ----------------------------------------------------------------------------
module generational_handle_allocator #(
  parameter int SLOTS    = gha_pkg::SLOTS_DEF,
  parameter int GEN_BITS = gha_pkg::GEN_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [gha_pkg::CMD_W-1:0]     cmd,
  input  logic [gha_pkg::IDX_FW-1:0]    handle_index,
  input  logic [gha_pkg::GEN_FW-1:0]    handle_generation,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gha_pkg::STATUS_W-1:0]  status,
  output logic [gha_pkg::IDX_FW-1:0]    out_index,
  output logic [gha_pkg::GEN_FW-1:0]    out_generation,
  output logic                          is_alive
);
  import gha_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TW = $clog2(SLOTS + 1);
  localparam int CW = (TW > IDX_FW) ? TW : IDX_FW + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  // memories
  logic [GEN_BITS:0] slot_mem  [SLOTS];
  logic [IW-1:0]     stack_mem [SLOTS];

  logic              slot_re, slot_we, stack_re, stack_we;
  logic [IW-1:0]     slot_raddr, slot_waddr, stack_raddr, stack_waddr, stack_wdata;
  logic [GEN_BITS:0] slot_wdata, slot_rdata;
  logic [IW-1:0]     stack_rdata;

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    if (slot_re) slot_rdata <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk) begin
    if (stack_we) stack_mem[stack_waddr] <= stack_wdata;
    if (stack_re) stack_rdata <= stack_mem[stack_raddr];
  end

  // control and captured command
  logic [1:0]          state, state_next;
  logic [TW-1:0]       top, top_next;
  logic [TW-1:0]       fresh, fresh_next;
  logic [CMD_W-1:0]    c_cmd;
  logic [IDX_FW-1:0]   c_hidx;
  logic [GEN_FW-1:0]   c_hgen;
  logic                c_in_range;
  logic [IW-1:0]       sel_idx, sel_idx_next;
  logic                from_fresh, from_fresh_next;
  logic                out_load;
  logic [STATUS_W-1:0] res_status;
  logic [IDX_FW-1:0]   res_idx;
  logic [GEN_FW-1:0]   res_gen;
  logic                res_alive;

  logic [CW-1:0]       hidx_wide;
  logic [IW-1:0]       hidx_addr;
  logic                hidx_in_range;
  logic                slot_ok, alive_cur, live;
  logic [GEN_BITS-1:0] gen_cur, gen_inc, gen_new;

  assign hidx_wide     = CW'(handle_index);
  assign hidx_addr     = hidx_wide[IW-1:0];
  assign hidx_in_range = hidx_wide < CW'(SLOTS);

  // entries at or above the fresh count were never written: generation 1, dead
  assign slot_ok   = TW'(sel_idx) < fresh;
  assign gen_cur   = slot_ok ? slot_rdata[GEN_BITS-1:0] : GEN_BITS'(1);
  assign alive_cur = slot_ok & slot_rdata[GEN_BITS];
  assign live      = c_in_range && (c_hgen != '0) && alive_cur &&
                     (32'(gen_cur) == 32'(c_hgen));
  assign gen_inc   = gen_cur + GEN_BITS'(1);
  assign gen_new   = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;

  always_comb begin
    state_next      = state;
    top_next        = top;
    fresh_next      = fresh;
    sel_idx_next    = sel_idx;
    from_fresh_next = from_fresh;
    in_stall        = (state != S_IDLE);
    slot_re         = 1'b0;
    slot_raddr      = hidx_addr;
    slot_we         = 1'b0;
    slot_waddr      = sel_idx;
    slot_wdata      = '0;
    stack_re        = 1'b0;
    stack_raddr     = IW'(top - TW'(1));
    stack_we        = 1'b0;
    stack_waddr     = top[IW-1:0];
    stack_wdata     = sel_idx;
    out_load        = 1'b0;
    res_status      = ST_OK;
    res_idx         = c_hidx;
    res_gen         = c_hgen;
    res_alive       = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (cmd == CMD_CREATE) begin
            if (top == '0) begin
              state_next = S_EXEC;
            end else if ((TW+1)'(top) + (TW+1)'(fresh) == (TW+1)'(SLOTS)) begin
              // stack is down to its untouched part: next index is the fresh count
              sel_idx_next    = IW'(fresh);
              from_fresh_next = 1'b1;
              state_next      = S_EXEC;
            end else begin
              stack_re        = 1'b1;
              from_fresh_next = 1'b0;
              state_next      = S_POP;
            end
          end else begin
            slot_re      = 1'b1;
            sel_idx_next = hidx_addr;
            state_next   = S_EXEC;
          end
        end
      end
      S_POP: begin
        slot_re      = 1'b1;
        slot_raddr   = stack_rdata;
        sel_idx_next = stack_rdata;
        state_next   = S_EXEC;
      end
      S_EXEC: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
          case (c_cmd)
            CMD_CREATE: begin
              if (top == '0) begin
                res_status = ST_NO_SLOT;
              end else begin
                top_next   = top - TW'(1);
                if (from_fresh) fresh_next = fresh + TW'(1);
                slot_we    = 1'b1;
                slot_wdata = {1'b1, gen_cur};
                res_idx    = IDX_FW'(sel_idx);
                res_gen    = GEN_FW'(gen_cur);
                res_alive  = 1'b1;
              end
            end
            CMD_DESTROY: begin
              if (live) begin
                slot_we    = 1'b1;
                slot_wdata = {1'b0, gen_new};
                if (top < TW'(SLOTS)) begin
                  stack_we = 1'b1;
                  top_next = top + TW'(1);
                end
                res_alive = 1'b1;
              end else begin
                res_status = ST_DEAD;
              end
            end
            default: begin
              if (live) res_alive = 1'b1;
              else      res_status = ST_DEAD;
            end
          endcase
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      top       <= TW'(SLOTS);
      fresh     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      top   <= top_next;
      fresh <= fresh_next;
      if (out_load)       out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    sel_idx    <= sel_idx_next;
    from_fresh <= from_fresh_next;
    if (state == S_IDLE && in_valid) begin
      c_cmd      <= cmd;
      c_hidx     <= handle_index;
      c_hgen     <= handle_generation;
      c_in_range <= hidx_in_range;
    end
    if (out_load) begin
      status         <= res_status;
      out_index      <= res_idx;
      out_generation <= res_gen;
      is_alive       <= res_alive;
    end
  end

endmodule

// ----- rtl/gha_checker.sv -----
// ----------------------------------------------------------------------------
// gha_checker
// Port-level checks of the generational handle allocator, bound to the top.
// ----------------------------------------------------------------------------
`include "generational_handle_allocator_assert.svh"

module gha_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [gha_pkg::CMD_W-1:0]     cmd,
  input logic [gha_pkg::IDX_FW-1:0]    handle_index,
  input logic [gha_pkg::GEN_FW-1:0]    handle_generation,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [gha_pkg::STATUS_W-1:0]  status,
  input logic [gha_pkg::IDX_FW-1:0]    out_index,
  input logic [gha_pkg::GEN_FW-1:0]    out_generation,
  input logic                          is_alive
);
  import gha_pkg::*;

  logic [STATUS_W+IDX_FW+GEN_FW:0] out_word;
  logic                            out_wait;
  logic                            in_take;
  logic                            ok_code;
  logic                            known_code;

  assign out_word   = {status, out_index, out_generation, is_alive};
  assign out_wait   = out_valid && out_stall;
  assign in_take    = in_valid && !in_stall;
  assign ok_code    = (status == ST_OK);
  assign known_code = (status == ST_OK) || (status == ST_NO_SLOT) || (status == ST_DEAD);

  // a stalled result word holds
  `GHA_ASSERT_NEXT(a_out_hold, clk, rst, out_wait, out_valid && $stable(out_word), "word changed")

  // one word in flight: the input closes right after an accept
  `GHA_ASSERT_NEXT(a_one_in_flight, clk, rst, in_take, in_stall, "input open after accept")

  // a handle reads as alive exactly when the command succeeded
  `GHA_ASSERT_NOW(a_alive_ok, clk, rst, out_valid, is_alive == ok_code, "is_alive vs status")

  // only the three defined status codes appear
  `GHA_ASSERT_NOW(a_status_code, clk, rst, out_valid, known_code, "undefined status code")

endmodule

bind generational_handle_allocator gha_checker u_gha_checker (.*);

// ----- test/generational_handle_allocator_test.sv -----
// ----------------------------------------------------------------------------
// generational_handle_allocator_test
// Self-checking bench for the handle allocator. A short table of directed
// commands runs first, then random traffic of creates, live-handle commands
// and noise, and a fill of every slot up to stack-empty failures. Each
// result word is compared with the word predicted from a private copy of
// the stack, generation and alive tables. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module generational_handle_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gha_pkg::*;

  // code 3 decodes as check
  localparam logic [CMD_W-1:0] CMD_CHECK_ALT = 2'd3;
  localparam int SLOT_COUNT = SLOTS_DEF;
  localparam int IDLE_PCT   = 34;
  localparam int CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_FW-1:0]   index;
    logic [GEN_FW-1:0]   gen;
    logic                alive;
  } result_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [IDX_FW-1:0] index;
    logic [GEN_FW-1:0] gen;
    logic              typed;
    result_t           want;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CMD_W-1:0]     cmd = CMD_CREATE;
  logic [IDX_FW-1:0]    handle_index = '0;
  logic [GEN_FW-1:0]    handle_generation = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [STATUS_W-1:0]  status;
  logic [IDX_FW-1:0]    out_index;
  logic [GEN_FW-1:0]    out_generation;
  logic                 is_alive;

  generational_handle_allocator dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .handle_index(handle_index),
    .handle_generation(handle_generation),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .out_index(out_index),
    .out_generation(out_generation),
    .is_alive(is_alive)
  );

  always #5 clk = ~clk;

  // shadow copy of the allocator tables
  logic [GEN_FW-1:0] slot_gen [SLOT_COUNT];
  bit                slot_live [SLOT_COUNT];
  logic [IDX_FW-1:0] free_slots [SLOT_COUNT];
  int                free_top;
  int                live_count;

  result_t pending_results[$];
  int      errors = 0;
  int      cycle_count = 0;
  bit      idle_on = 1'b1;

  dir_row_t directed [0:20] = '{
    '{CMD_CREATE,    10'd0,    16'd0,     1'b1, '{ST_OK,    10'd0,    16'd1,     1'b1}},
    '{CMD_CREATE,    10'd1023, 16'hFFFF,  1'b1, '{ST_OK,    10'd1,    16'd1,     1'b1}},
    '{CMD_CHECK,     10'd0,    16'd1,     1'b1, '{ST_OK,    10'd0,    16'd1,     1'b1}},
    '{CMD_CHECK,     10'd0,    16'd0,     1'b1, '{ST_DEAD,  10'd0,    16'd0,     1'b0}},
    '{CMD_CHECK,     10'd1023, 16'hFFFF,  1'b1, '{ST_DEAD,  10'd1023, 16'hFFFF,  1'b0}},
    '{CMD_CHECK,     10'd2,    16'd1,     1'b1, '{ST_DEAD,  10'd2,    16'd1,     1'b0}},
    '{CMD_CHECK,     10'd1,    16'd2,     1'b1, '{ST_DEAD,  10'd1,    16'd2,     1'b0}},
    '{CMD_CHECK_ALT, 10'd1,    16'd1,     1'b1, '{ST_OK,    10'd1,    16'd1,     1'b1}},
    '{CMD_DESTROY,   10'd0,    16'd0,     1'b1, '{ST_DEAD,  10'd0,    16'd0,     1'b0}},
    '{CMD_DESTROY,   10'd0,    16'd1,     1'b1, '{ST_OK,    10'd0,    16'd1,     1'b1}},
    '{CMD_DESTROY,   10'd0,    16'd1,     1'b1, '{ST_DEAD,  10'd0,    16'd1,     1'b0}},
    '{CMD_CHECK,     10'd0,    16'd1,     1'b1, '{ST_DEAD,  10'd0,    16'd1,     1'b0}},
    '{CMD_CREATE,    10'd5,    16'd5,     1'b1, '{ST_OK,    10'd0,    16'd2,     1'b1}},
    '{CMD_DESTROY,   10'd1,    16'd1,     1'b1, '{ST_OK,    10'd1,    16'd1,     1'b1}},
    '{CMD_DESTROY,   10'd0,    16'd2,     1'b1, '{ST_OK,    10'd0,    16'd2,     1'b1}},
    '{CMD_CREATE,    10'd0,    16'd0,     1'b1, '{ST_OK,    10'd0,    16'd3,     1'b1}},
    '{CMD_CREATE,    10'd0,    16'd0,     1'b1, '{ST_OK,    10'd1,    16'd2,     1'b1}},
    '{CMD_CREATE,    10'd0,    16'd0,     1'b1, '{ST_OK,    10'd2,    16'd1,     1'b1}},
    '{CMD_DESTROY,   10'd1023, 16'd1,     1'b0, '0},
    '{CMD_CHECK_ALT, 10'd512,  16'h5555,  1'b0, '0},
    '{CMD_DESTROY,   10'd2,    16'd1,     1'b1, '{ST_OK,    10'd2,    16'd1,     1'b1}}
  };

  function automatic bit handle_is_live(logic [IDX_FW-1:0] idx, logic [GEN_FW-1:0] gen);
    return gen != '0 && slot_live[idx] && slot_gen[idx] == gen;
  endfunction

  // applies one command to the shadow tables and returns the word it yields
  function automatic result_t allocate_step(logic [CMD_W-1:0] c, logic [IDX_FW-1:0] idx,
                                            logic [GEN_FW-1:0] gen);
    result_t r;
    logic [IDX_FW-1:0] s;
    logic [GEN_FW-1:0] g;
    bit live;
    r = '{ST_OK, idx, gen, 1'b0};
    live = handle_is_live(idx, gen);
    if (c == CMD_CREATE) begin
      if (free_top == 0) begin
        r.status = ST_NO_SLOT;
      end else begin
        free_top--;
        s = free_slots[free_top];
        slot_live[s] = 1'b1;
        live_count++;
        r.index = s;
        r.gen = slot_gen[s];
        r.alive = 1'b1;
      end
    end else if (c == CMD_DESTROY) begin
      if (live) begin
        g = slot_gen[idx] + 1'b1;
        if (g == '0) g = GEN_FW'(1);
        slot_live[idx] = 1'b0;
        slot_gen[idx] = g;
        live_count--;
        if (free_top < SLOT_COUNT) begin
          free_slots[free_top] = idx;
          free_top++;
        end
        r.alive = 1'b1;
      end else begin
        r.status = ST_DEAD;
      end
    end else if (live) begin
      r.alive = 1'b1;
    end else begin
      r.status = ST_DEAD;
    end
    return r;
  endfunction

  // first live slot at or after a random point
  function automatic int pick_live();
    int start;
    int k;
    start = $urandom_range(SLOT_COUNT - 1);
    for (k = 0; k < SLOT_COUNT; k++) begin
      if (slot_live[(start + k) % SLOT_COUNT]) return (start + k) % SLOT_COUNT;
    end
    return 0;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= 50)
      $display("mismatch %s: got %0h expected %0h, cycle %0d", what, got, want, cycle_count);
  endtask

  task automatic send_word(input logic [CMD_W-1:0] c, input logic [IDX_FW-1:0] idx,
                           input logic [GEN_FW-1:0] gen, input bit typed,
                           input result_t typed_r, output result_t pred);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    handle_index <= idx;
    handle_generation <= gen;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = allocate_step(c, idx, gen);
    pending_results.push_back(typed ? typed_r : pred);
  endtask

  task automatic send(input logic [CMD_W-1:0] c, input logic [IDX_FW-1:0] idx,
                      input logic [GEN_FW-1:0] gen, output result_t pred);
    send_word(c, idx, gen, 1'b0, '0, pred);
  endtask

  task automatic send_create();
    result_t r;
    send(CMD_CREATE, IDX_FW'($urandom), GEN_FW'($urandom), r);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_mix(int n, int create_pct);
    result_t r;
    int roll;
    int idx;
    logic [GEN_FW-1:0] gen;
    repeat (n) begin
      roll = $urandom_range(99);
      if (roll < create_pct || live_count == 0) begin
        send_create();
      end else if (roll < create_pct + 30) begin
        idx = pick_live();
        send(CMD_DESTROY, IDX_FW'(idx), slot_gen[idx], r);
      end else if (roll < create_pct + 45) begin
        idx = pick_live();
        send($urandom_range(1) ? CMD_CHECK : CMD_CHECK_ALT, IDX_FW'(idx), slot_gen[idx], r);
      end else begin
        // noise: stale, zero, all-ones or random handles under any code
        idx = $urandom_range(SLOT_COUNT - 1);
        case ($urandom_range(3))
          0: gen = GEN_FW'($urandom);
          1: gen = '0;
          2: gen = '1;
          default: gen = slot_gen[idx] - GEN_FW'($urandom_range(1));
        endcase
        send(CMD_W'($urandom_range(3)), IDX_FW'(idx), gen, r);
      end
    end
  endtask

  task automatic fill_all();
    result_t r;
    int idx;
    while (free_top > 0) begin
      send_create();
      if ($urandom_range(9) == 0) begin
        idx = pick_live();
        send(CMD_CHECK, IDX_FW'(idx), slot_gen[idx], r);
      end
    end
    // stack empty: creates must fail until a slot comes back
    repeat (6) send_create();
    idx = pick_live();
    send(CMD_DESTROY, IDX_FW'(idx), slot_gen[idx], r);
    send_create();
    send_create();
  endtask

  always @(posedge clk) begin : collect
    result_t got;
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{status, out_index, out_generation, is_alive};
      if (pending_results.size() == 0) begin
        report("word with nothing pending", got, '0);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) report("status", got.status, want.status);
        if (got.index !== want.index) report("out_index", got.index, want.index);
        if (got.gen !== want.gen) report("out_generation", got.gen, want.gen);
        if (got.alive !== want.alive) report("is_alive", got.alive, want.alive);
      end
    end
    out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    result_t r;
    int i;
    for (i = 0; i < SLOT_COUNT; i++) begin
      slot_gen[i] = GEN_FW'(1);
      slot_live[i] = 1'b0;
      free_slots[i] = IDX_FW'(SLOT_COUNT - 1 - i);
    end
    free_top = SLOT_COUNT;
    live_count = 0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i <= 20; i++)
      send_word(directed[i].cmd, directed[i].index, directed[i].gen, directed[i].typed,
                directed[i].want, r);

    run_mix(100, 45);
    fill_all();
    run_mix(100, 15);
    wait_drained();
    run_mix(60, 40);

    // long stretch without idling on either side
    idle_on = 1'b0;
    run_mix(80, 40);
    idle_on = 1'b1;
    run_mix(40, 40);

    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
